@@ src/bmh_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the binary min-heap.
package bmh_pkg;

    // Default sizes
    localparam int HEAP_DEPTH = 256;
    localparam int KEY_WIDTH  = 32;
    localparam int REF_WIDTH  = 9;

    // Fixed field widths
    localparam int CAP_W    = 9;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;
    localparam int CMD_W    = 1;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Request commands
    localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // take the request, set up position, count and status
        logic rd_parent;  // read the parent of the current position
        logic up_move;    // parent moves down into the hole, hole moves up
        logic place;      // write the moving entry at the hole, done
        logic take_root;  // capture old root as result, last entry starts moving
        logic rd_child;   // read both children of the hole
        logic dn_move;    // chosen child moves up into the hole, hole moves down
        logic emit;       // load the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_insert;
        logic full;
        logic empty;
        logic pos_zero;
        logic up_move;
        logic dn_has_child;
        logic dn_move;
        logic out_free;
    } t_dp_stat;

endpackage

@@ src/binary_min_heap.sv @@
// Top level of the binary min-heap priority queue.
//
// Requests arrive on the s_axis channel: tuser selects insert (0) or delete minimum (1),
// tdata carries the key and node reference to insert. Each request yields exactly one
// result on the m_axis channel: tuser holds the status (done, insert dropped because
// full, delete on empty heap), tdata holds the removed key and reference (zero for
// inserts and failed deletes) and the entry count after the request.
// The capacity register is written through i_cfg_wr_en / i_cfg_wr_data; the user must
// write it only while idle, the block itself does not enforce this. One request is worked
// at a time. The moving entry passes at most log2(HEAP_DEPTH) levels, 8 at the default
// depth; a full insert or empty delete goes straight to the result. Each level costs one
// read of the entry store (registered read) and one compare-and-write step; the store has
// one write and two read ports.
// The result sits in an output register; the next request is accepted while it waits,
// and a finished request holds in the sequencer until that register is free.
// Synchronous active-low reset empties the heap, sets capacity to 256 and drops any
// pending result; store contents are left as they were.
module binary_min_heap #(
    parameter int HEAP_DEPTH = bmh_pkg::HEAP_DEPTH,
    parameter int KEY_WIDTH  = bmh_pkg::KEY_WIDTH,
    parameter int REF_WIDTH  = bmh_pkg::REF_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [bmh_pkg::CAP_W-1:0]             i_cfg_wr_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // entry_key, node_ref, zero fill
    input  logic [((KEY_WIDTH+REF_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // command
    input  logic [bmh_pkg::CMD_W-1:0]             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_key, out_ref, count, zero fill
    output logic [((KEY_WIDTH+REF_WIDTH+bmh_pkg::COUNT_W+7)/8)*8-1:0] m_axis_tdata,
    // status
    output logic [bmh_pkg::STATUS_W-1:0]          m_axis_tuser
);

    localparam int OUT_W = ((KEY_WIDTH + REF_WIDTH + bmh_pkg::COUNT_W + 7) / 8) * 8;

    bmh_pkg::t_dp_cmd  w_cmd;
    bmh_pkg::t_dp_stat w_stat;

    logic [KEY_WIDTH-1:0]        w_out_key;
    logic [REF_WIDTH-1:0]        w_out_ref;
    logic [bmh_pkg::COUNT_W-1:0] w_out_count;

    // Sequencer
    bmh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // Datapath and entry store
    bmh_datapath #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .KEY_WIDTH  (KEY_WIDTH),
        .REF_WIDTH  (REF_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_cmd      (s_axis_tuser),
        .i_in_key      (s_axis_tdata[KEY_WIDTH-1:0]),
        .i_in_ref      (s_axis_tdata[KEY_WIDTH+REF_WIDTH-1:KEY_WIDTH]),
        .i_out_ready   (m_axis_tready),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out_valid   (m_axis_tvalid),
        .o_out_status  (m_axis_tuser),
        .o_out_key     (w_out_key),
        .o_out_ref     (w_out_ref),
        .o_out_count   (w_out_count)
    );

    // Result packing, zero fill at the top
    assign m_axis_tdata = OUT_W'({w_out_count, w_out_ref, w_out_key});

`ifndef SYNTHESIS
    // A request is taken only from idle, so the next cycle is busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while a previous one is still in work");

    // The result register is never overwritten while a result waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && m_axis_tvalid) |-> m_axis_tready)
        else $error("pending result overwritten");

    // A delete on an empty heap reports zero entries and a zero key
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == bmh_pkg::ST_EMPTY)) |->
        ((w_out_count == '0) && (w_out_key == '0) && (w_out_ref == '0)))
        else $error("empty delete result carries data");

    // The reported count never exceeds the heap depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(w_out_count) <= 32'(HEAP_DEPTH)))
        else $error("entry count above heap depth");
`endif

endmodule

@@ src/bmh_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
module bmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ src/bmh_ctrl.sv @@
// Sequencer for insert (sift up) and delete (sift down) requests of the heap.
module bmh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bmh_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output bmh_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_UP_RD   = 7'b0000010,
        S_UP_CMP  = 7'b0000100,
        S_DN_ROOT = 7'b0001000,
        S_DN_RD   = 7'b0010000,
        S_DN_CMP  = 7'b0100000,
        S_EMIT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.in_insert) begin
                        n_state = i_stat.full ? S_EMIT : S_UP_RD;
                    end else begin
                        n_state = i_stat.empty ? S_EMIT : S_DN_ROOT;
                    end
                end
            end
            S_UP_RD: begin
                if (i_stat.pos_zero) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_EMIT;
                end else begin
                    o_cmd.rd_parent = 1'b1;
                    n_state         = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_move) begin
                    o_cmd.up_move = 1'b1;
                    n_state       = S_UP_RD;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_EMIT;
                end
            end
            S_DN_ROOT: begin
                o_cmd.take_root = 1'b1;
                n_state         = S_DN_RD;
            end
            S_DN_RD: begin
                if (i_stat.dn_has_child) begin
                    o_cmd.rd_child = 1'b1;
                    n_state        = S_DN_CMP;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_EMIT;
                end
            end
            S_DN_CMP: begin
                if (i_stat.dn_move) begin
                    o_cmd.dn_move = 1'b1;
                    n_state       = S_DN_RD;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/bmh_datapath.sv @@
// Heap datapath: entry store, hole position, count, capacity and result register.
module bmh_datapath #(
    parameter int HEAP_DEPTH = bmh_pkg::HEAP_DEPTH,
    parameter int KEY_WIDTH  = bmh_pkg::KEY_WIDTH,
    parameter int REF_WIDTH  = bmh_pkg::REF_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [bmh_pkg::CAP_W-1:0]     i_cfg_wr_data,
    input  logic [bmh_pkg::CMD_W-1:0]     i_in_cmd,
    input  logic [KEY_WIDTH-1:0]          i_in_key,
    input  logic [REF_WIDTH-1:0]          i_in_ref,
    input  logic                          i_out_ready,
    input  bmh_pkg::t_dp_cmd              i_cmd,
    output bmh_pkg::t_dp_stat             o_stat,
    output logic                          o_out_valid,
    output logic [bmh_pkg::STATUS_W-1:0]  o_out_status,
    output logic [KEY_WIDTH-1:0]          o_out_key,
    output logic [REF_WIDTH-1:0]          o_out_ref,
    output logic [bmh_pkg::COUNT_W-1:0]   o_out_count
);

    localparam int AW    = $clog2(HEAP_DEPTH);
    localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
    localparam int WORD  = KEY_WIDTH + REF_WIDTH;

    // Registers
    logic [bmh_pkg::CAP_W-1:0]    r_cap;
    logic [CNT_W-1:0]             r_count;
    logic [AW-1:0]                r_pos;
    logic [AW-1:0]                r_last;
    logic [KEY_WIDTH-1:0]         r_ent_key;
    logic [REF_WIDTH-1:0]         r_ent_ref;
    logic [bmh_pkg::STATUS_W-1:0] r_res_status;
    logic [KEY_WIDTH-1:0]         r_res_key;
    logic [REF_WIDTH-1:0]         r_res_ref;
    logic                         r_out_valid;
    logic [bmh_pkg::STATUS_W-1:0] r_out_status;
    logic [KEY_WIDTH-1:0]         r_out_key;
    logic [REF_WIDTH-1:0]         r_out_ref;
    logic [bmh_pkg::COUNT_W-1:0]  r_out_count;

    // Store ports
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [WORD-1:0] w_wdata;
    logic [AW-1:0]   w_raddr_a;
    logic [AW-1:0]   w_raddr_b;
    logic [WORD-1:0] w_rdata_a;
    logic [WORD-1:0] w_rdata_b;

    // Index arithmetic
    logic [31:0]     w_count_ext;
    logic            w_full;
    logic            w_empty;
    logic [AW-1:0]   w_parent;
    logic [AW:0]     w_child1;
    logic [AW:0]     w_child2;
    logic [AW:0]     w_last_ext;
    logic            w_has_child;
    logic            w_pick_right;
    logic [AW-1:0]   w_child_idx;
    logic [WORD-1:0] w_child_word;
    logic [WORD-1:0] w_ent_word;

    assign w_count_ext = 32'(r_count);
    assign w_full      = (w_count_ext >= 32'(r_cap)) || (w_count_ext >= 32'(HEAP_DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_parent    = (r_pos - AW'(1)) >> 1;
    assign w_child1    = {r_pos, 1'b1};
    assign w_child2    = w_child1 + (AW + 1)'(1);
    assign w_last_ext  = {1'b0, r_last};
    assign w_has_child = (w_child1 < w_last_ext);
    assign w_ent_word  = {r_ent_ref, r_ent_key};

    // Right child only when it exists and the left key is strictly greater
    assign w_pick_right = (w_child2 < w_last_ext) &&
                          (w_rdata_a[KEY_WIDTH-1:0] > w_rdata_b[KEY_WIDTH-1:0]);
    assign w_child_idx  = w_pick_right ? w_child2[AW-1:0] : w_child1[AW-1:0];
    assign w_child_word = w_pick_right ? w_rdata_b : w_rdata_a;

    // Status to controller
    always_comb begin
        o_stat.in_insert    = (i_in_cmd == bmh_pkg::CMD_INSERT);
        o_stat.full         = w_full;
        o_stat.empty        = w_empty;
        o_stat.pos_zero     = (r_pos == '0);
        o_stat.up_move      = (r_ent_key < w_rdata_a[KEY_WIDTH-1:0]);
        o_stat.dn_has_child = w_has_child;
        o_stat.dn_move      = (r_ent_key > w_child_word[KEY_WIDTH-1:0]);
        o_stat.out_free     = !r_out_valid || i_out_ready;
    end

    // Store read addresses: root and last on load, parent or children while sifting
    always_comb begin
        w_raddr_a = '0;
        w_raddr_b = AW'(r_count - CNT_W'(1));
        if (i_cmd.rd_parent) begin
            w_raddr_a = w_parent;
        end else if (i_cmd.rd_child) begin
            w_raddr_a = w_child1[AW-1:0];
            w_raddr_b = w_child2[AW-1:0];
        end
    end

    // Store write: a displaced entry moves into the hole, or the moving entry settles
    always_comb begin
        w_we    = i_cmd.up_move || i_cmd.dn_move || i_cmd.place;
        w_waddr = r_pos;
        w_wdata = w_ent_word;
        if (i_cmd.up_move) begin
            w_wdata = w_rdata_a;
        end else if (i_cmd.dn_move) begin
            w_wdata = w_child_word;
        end
    end

    bmh_ram #(
        .WIDTH (WORD),
        .DEPTH (HEAP_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= bmh_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            if ((i_in_cmd == bmh_pkg::CMD_INSERT) && !w_full) begin
                r_count <= r_count + CNT_W'(1);
            end else if ((i_in_cmd == bmh_pkg::CMD_DELETE) && !w_empty) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Hole position, moving entry and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ent_key <= i_in_key;
            r_ent_ref <= i_in_ref;
            r_res_key <= '0;
            r_res_ref <= '0;
            r_pos     <= AW'(r_count);
            r_last    <= AW'(r_count - CNT_W'(1));
            if (i_in_cmd == bmh_pkg::CMD_INSERT) begin
                r_res_status <= w_full ? bmh_pkg::ST_FULL : bmh_pkg::ST_DONE;
            end else begin
                r_res_status <= w_empty ? bmh_pkg::ST_EMPTY : bmh_pkg::ST_DONE;
            end
        end
        if (i_cmd.take_root) begin
            r_res_key <= w_rdata_a[KEY_WIDTH-1:0];
            r_res_ref <= w_rdata_a[WORD-1:KEY_WIDTH];
            r_ent_key <= w_rdata_b[KEY_WIDTH-1:0];
            r_ent_ref <= w_rdata_b[WORD-1:KEY_WIDTH];
            r_pos     <= '0;
        end
        if (i_cmd.up_move) begin
            r_pos <= w_parent;
        end
        if (i_cmd.dn_move) begin
            r_pos <= w_child_idx;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= r_res_status;
            r_out_key    <= r_res_key;
            r_out_ref    <= r_res_ref;
            r_out_count  <= w_count_ext[bmh_pkg::COUNT_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_key    = r_out_key;
    assign o_out_ref    = r_out_ref;
    assign o_out_count  = r_out_count;

endmodule

@@ test/binary_min_heap_test.sv @@
// Self-checking testbench for the binary min-heap: directed, random and back-pressure runs.
module binary_min_heap_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KW      = bmh_pkg::KEY_WIDTH;
    localparam int RW      = bmh_pkg::REF_WIDTH;
    localparam int DEPTH   = bmh_pkg::HEAP_DEPTH;
    localparam int CW      = bmh_pkg::COUNT_W;
    localparam int STW     = bmh_pkg::STATUS_W;
    localparam int CAPW    = bmh_pkg::CAP_W;
    localparam int CMDW    = bmh_pkg::CMD_W;
    localparam int S_W     = ((KW + RW + 7) / 8) * 8;
    localparam int M_W     = ((KW + RW + CW + 7) / 8) * 8;
    localparam int HOLD_LEN    = 300;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 30;

    // One result as it is expected on the master side
    typedef struct packed {
        logic [STW-1:0] status;
        logic [KW-1:0]  out_key;
        logic [RW-1:0]  out_ref;
        logic [CW-1:0]  count;
    } t_heap_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CAPW-1:0]  i_cfg_wr_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [S_W-1:0]   s_axis_tdata;   // entry_key, node_ref, zero fill
    logic [CMDW-1:0]  s_axis_tuser;   // command
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [M_W-1:0]   m_axis_tdata;   // out_key, out_ref, count, zero fill
    logic [STW-1:0]   m_axis_tuser;   // status

    binary_min_heap uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Heap predictor state
    logic [KW-1:0] model_keys [DEPTH];
    logic [RW-1:0] model_refs [DEPTH];
    int            model_count;
    int            model_capacity;

    t_heap_result  pending_results [$];
    int            mismatch_count;
    int            cycle_count;

    // Idle rates in percent, and the long receiver hold-off
    int            sender_idle_pct;
    int            recv_idle_pct;
    int            hold_ticket;
    int            hold_seen;
    int            hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[binary_min_heap] ERROR");
            $finish;
        end
    end

    // Receiver: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_seen     <= 0;
            hold_left     <= 0;
        end else if (hold_ticket != hold_seen) begin
            hold_seen     <= hold_ticket;
            hold_left     <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker: each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_heap_result exp_r;
        t_heap_result got_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_r.status  = m_axis_tuser;
            got_r.out_key = m_axis_tdata[KW-1:0];
            got_r.out_ref = m_axis_tdata[KW+RW-1:KW];
            got_r.count   = m_axis_tdata[KW+RW+CW-1:KW+RW];
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: status %0d key %h ref %0d count %0d",
                             got_r.status, got_r.out_key, got_r.out_ref, got_r.count);
                mismatch_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got_r != exp_r) begin
                    if (mismatch_count < 10) begin
                        $display("mismatch: exp status %0d key %h ref %0d count %0d,",
                                 exp_r.status, exp_r.out_key, exp_r.out_ref, exp_r.count);
                        $display("          got status %0d key %h ref %0d count %0d",
                                 got_r.status, got_r.out_key, got_r.out_ref, got_r.count);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    function automatic void swap_entries(input int a, input int b);
        logic [KW-1:0] tk;
        logic [RW-1:0] tr;
        tk = model_keys[a];
        tr = model_refs[a];
        model_keys[a] = model_keys[b];
        model_refs[a] = model_refs[b];
        model_keys[b] = tk;
        model_refs[b] = tr;
    endfunction

    // Predict the result of one accepted request and update the heap copy
    function automatic void apply_heap_request(input logic [CMDW-1:0] cmd,
                                               input logic [KW-1:0] key,
                                               input logic [RW-1:0] node);
        t_heap_result r;
        int cap;
        int i;
        int k;
        int c;
        int last;
        r   = '0;
        cap = (model_capacity > DEPTH) ? DEPTH : model_capacity;
        if (cmd == bmh_pkg::CMD_INSERT) begin
            if (model_count >= cap) begin
                r.status = bmh_pkg::ST_FULL;
            end else begin
                i = model_count;
                model_keys[i] = key;
                model_refs[i] = node;
                // sift up while strictly below the parent
                while (i > 0 && model_keys[i] < model_keys[(i - 1) / 2]) begin
                    swap_entries(i, (i - 1) / 2);
                    i = (i - 1) / 2;
                end
                model_count++;
                r.status = bmh_pkg::ST_DONE;
            end
        end else begin
            if (model_count == 0) begin
                r.status = bmh_pkg::ST_EMPTY;
            end else begin
                last = model_count - 1;
                r.status  = bmh_pkg::ST_DONE;
                r.out_key = model_keys[0];
                r.out_ref = model_refs[0];
                model_keys[0] = model_keys[last];
                model_refs[0] = model_refs[last];
                model_count = last;
                k = 0;
                // sift down; right child only when the left one is strictly greater
                while (2 * k + 1 < last) begin
                    c = 2 * k + 1;
                    if (c + 1 < last && model_keys[c] > model_keys[c + 1])
                        c = c + 1;
                    if (model_keys[k] > model_keys[c]) begin
                        swap_entries(k, c);
                        k = c;
                    end else begin
                        break;
                    end
                end
            end
        end
        r.count = CW'(model_count);
        pending_results.push_back(r);
    endfunction

    // Send one request; returns in the step where it was accepted
    task automatic send_request(input logic [CMDW-1:0] cmd, input logic [KW-1:0] key,
                                input logic [RW-1:0] node);
        int gap;
        gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {{(S_W-KW-RW){1'b0}}, RW'($urandom), KW'($urandom)};
            s_axis_tuser  <= CMDW'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_W-KW-RW){1'b0}}, node, key};
        s_axis_tuser  <= cmd;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready)
                break;
        end
        apply_heap_request(cmd, key, node);
    endtask

    // Stop offering and wait until every expected result has been taken
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_capacity(input int value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= CAPW'(value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        model_capacity = value;
    endtask

    function automatic logic [KW-1:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)      return KW'($urandom);
        else if (sel < 80) return KW'($urandom_range(0, 15));
        else if (sel < 90) return '0;
        else               return '1;
    endfunction

    // Random requests, insert share chosen per 16-request chunk unless fixed
    task automatic run_random(input int n, input int fixed_insert_pct);
        int ins_pct;
        int mode;
        ins_pct = 50;
        for (int j = 0; j < n; j++) begin
            if (fixed_insert_pct >= 0) begin
                ins_pct = fixed_insert_pct;
            end else if (j % 16 == 0) begin
                mode = $urandom_range(2);
                ins_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
            end
            if ($urandom_range(99) < ins_pct)
                send_request(bmh_pkg::CMD_INSERT, pick_key(), RW'($urandom));
            else
                send_request(bmh_pkg::CMD_DELETE, KW'($urandom), RW'($urandom));
        end
    endtask

    // Key and reference extremes, ties, empty and full cases, capacity corners
    task automatic test_directed();
        send_request(bmh_pkg::CMD_DELETE, '0, '0);
        send_request(bmh_pkg::CMD_INSERT, '1, '1);
        send_request(bmh_pkg::CMD_INSERT, '0, '0);
        send_request(bmh_pkg::CMD_INSERT, KW'(32'h8000_0000), RW'(9'h155));
        send_request(bmh_pkg::CMD_INSERT, KW'(5), RW'(1));
        send_request(bmh_pkg::CMD_INSERT, KW'(5), RW'(2));
        repeat (6) send_request(bmh_pkg::CMD_DELETE, '1, '1);
        write_capacity(1);
        send_request(bmh_pkg::CMD_INSERT, KW'(32'h5555_5555), RW'(9'h0AA));
        send_request(bmh_pkg::CMD_INSERT, KW'(32'hAAAA_AAAA), RW'(9'h155));
        send_request(bmh_pkg::CMD_DELETE, '0, '0);
        send_request(bmh_pkg::CMD_DELETE, '0, '0);
        write_capacity(0);
        send_request(bmh_pkg::CMD_INSERT, KW'(7), RW'(7));
        write_capacity(511);
        send_request(bmh_pkg::CMD_INSERT, KW'(9), RW'(3));
        send_request(bmh_pkg::CMD_INSERT, KW'(1), RW'(4));
        send_request(bmh_pkg::CMD_INSERT, KW'(4), RW'(5));
        // capacity lowered below the count
        write_capacity(2);
        send_request(bmh_pkg::CMD_INSERT, KW'(2), RW'(6));
        repeat (3) send_request(bmh_pkg::CMD_DELETE, '0, '0);
    endtask

    // Fill to the full depth, then drain past empty
    task automatic test_fill_drain();
        write_capacity(DEPTH);
        run_random(300, 95);
        run_random(300, 5);
    endtask

    task automatic test_random_caps();
        write_capacity(7);
        run_random(200, -1);
        write_capacity(1);
        run_random(100, -1);
        write_capacity(511);
        run_random(200, -1);
    endtask

    // Receiver holds off long enough for the input to stall
    task automatic test_backpressure();
        write_capacity(20);
        hold_ticket = hold_ticket + 1;
        run_random(10, 70);
    endtask

    // Sender pauses until every result has come back
    task automatic test_drain_pause();
        write_capacity(12);
        run_random(10, 60);
        wait_drained();
        run_random(10, 40);
    endtask

    task automatic test_capacity_lowered();
        write_capacity(DEPTH);
        run_random(40, 100);
        write_capacity(5);
        run_random(30, 50);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= '0;
        s_axis_tvalid   <= 1'b0;
        s_axis_tdata    <= '0;
        s_axis_tuser    <= '0;
        hold_ticket     = 0;
        sender_idle_pct = 24;
        recv_idle_pct   = 69;
        model_count     = 0;
        model_capacity  = bmh_pkg::CAP_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_drain();

        sender_idle_pct = 69;
        recv_idle_pct   = 24;
        test_random_caps();

        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        test_backpressure();
        test_drain_pause();
        write_capacity(30);
        run_random(250, -1);
        test_capacity_lowered();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[binary_min_heap] OK");
        end else begin
            $display("[binary_min_heap] ERROR");
        end
        $finish;
    end

endmodule
